// File: hw/rtl/stq_pkg.sv
// Package for the sorted timer event queue.
// Holds the shared constants, request codes, status codes and the cell command struct.
// No dependencies.
package stq_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 16;

	localparam int TIME_BITS   = 48;
	localparam int DELAY_BITS  = 40;
	localparam int SLACK_BITS  = 20;
	localparam int HFIELD_BITS = 16;
	localparam int PEND_BITS   = 5;
	localparam int ADDR_BITS   = 3;
	localparam int DATA_BITS   = 32;

	localparam logic [SLACK_BITS-1:0] SLACK_RESET = SLACK_BITS'(10000);

	typedef enum logic {
		KIND_SCHEDULE = 1'b0,
		KIND_POLL     = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_SCHEDULED = 2'd0,
		ST_REJECTED  = 2'd1,
		ST_FIRED     = 2'd2,
		ST_NOT_DUE   = 2'd3
	} status_t;

	typedef enum logic {
		REG_EARLY_SLACK = 1'b0,
		REG_UNUSED      = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic                 ins;
		logic                 pop;
		logic [TIME_BITS-1:0] wake;
	} stq_cmd_t;

endpackage

// File: hw/rtl/stq_if.sv
// Request and response channel interfaces of the sorted timer event queue.
// Depends on stq_pkg for the field widths.
interface stq_req_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [stq_pkg::TIME_BITS-1:0]       now;
	logic [stq_pkg::DELAY_BITS-1:0]      delay;
	logic [stq_pkg::HFIELD_BITS-1:0]     handle;

	modport source (output valid, kind, now, delay, handle, input ready);
	modport sink (input valid, kind, now, delay, handle, output ready);
endinterface

interface stq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic [stq_pkg::HFIELD_BITS-1:0]     fired_handle;
	logic [stq_pkg::PEND_BITS-1:0]       pending;

	modport source (output valid, status, fired_handle, pending, input ready);
	modport sink (input valid, status, fired_handle, pending, output ready);
endinterface

// File: hw/rtl/stq_cell.sv
// One cell of the sorted chain: holds one wakeup time and handle.
// Depends on stq_pkg for the command struct and time width.
module stq_cell #(
	parameter int HANDLE_BITS = stq_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  stq_pkg::stq_cmd_t             cmd,
	input  logic [HANDLE_BITS-1:0]        new_handle,
	input  logic                          occupied,
	input  logic                          prev_keep,
	input  logic [stq_pkg::TIME_BITS-1:0] prev_time,
	input  logic [HANDLE_BITS-1:0]        prev_handle,
	input  logic [stq_pkg::TIME_BITS-1:0] next_time,
	input  logic [HANDLE_BITS-1:0]        next_handle,
	output logic [stq_pkg::TIME_BITS-1:0] ent_time_q,
	output logic [HANDLE_BITS-1:0]        ent_handle_q,
	output logic                          keep
);
	import stq_pkg::*;

	// An occupied cell whose time is not later than the new one stays in place.
	assign keep = occupied && (ent_time_q <= cmd.wake);

	always_ff @(posedge clk) begin
		if (cmd.ins && !keep) begin
			if (prev_keep) begin
				ent_time_q   <= cmd.wake;
				ent_handle_q <= new_handle;
			end else begin
				ent_time_q   <= prev_time;
				ent_handle_q <= prev_handle;
			end
		end else if (cmd.pop) begin
			ent_time_q   <= next_time;
			ent_handle_q <= next_handle;
		end
	end

endmodule

// File: hw/rtl/stq_apb.sv
// Configuration register block of the sorted timer event queue.
// Holds the early slack register behind an APB-style port; depends on stq_pkg.
module stq_apb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [stq_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [stq_pkg::DATA_BITS-1:0]  pwdata,
	output logic [stq_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output logic [stq_pkg::SLACK_BITS-1:0] early_slack
);
	import stq_pkg::*;

	logic [SLACK_BITS-1:0] slack_q;
	logic                  sel_slack;

	assign pready      = 1'b1;
	assign sel_slack   = (reg_index_t'(paddr[2]) == REG_EARLY_SLACK);
	assign early_slack = slack_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= SLACK_RESET;
		end else if (psel && penable && pwrite && pready && sel_slack) begin
			slack_q <= pwdata[SLACK_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_slack) begin
			prdata = DATA_BITS'(slack_q);
		end
	end

endmodule

// File: hw/rtl/sorted_timer_event_queue.sv
// Sorted timer event queue: a chain of DEPTH cells kept in wakeup-time order.
// A request first registers its wakeup time and due threshold; when the
// response register is free or being read, every cell then updates in parallel
// and the response register loads. Throughput is one request per cycle while
// the response side does not stall. Reset empties the queue and sets the early
// slack to 10000; cell contents are not cleared.
module sorted_timer_event_queue #(
	parameter int DEPTH       = stq_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = stq_pkg::HANDLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [stq_pkg::ADDR_BITS-1:0] paddr,
	input  logic [stq_pkg::DATA_BITS-1:0] pwdata,
	output logic [stq_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready,
	stq_req_if.sink                       req,
	stq_rsp_if.source                     rsp
);
	import stq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [SLACK_BITS-1:0]  early_slack;

	logic                   s1_valid_q;
	logic                   kind_s1;
	logic [TIME_BITS-1:0]   wake_s1;
	logic [TIME_BITS:0]     thresh_s1;
	logic [HANDLE_BITS-1:0] handle_s1;

	logic [TIME_BITS:0]     wake_sum;
	logic [31:0]            handle_wide;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	logic                   full;
	logic                   due;
	logic                   fire;
	stq_cmd_t               cmd;
	status_t                status_d;
	logic [HFIELD_BITS-1:0] fired_d;
	logic [31:0]            head_wide;
	logic [31:0]            count_wide;

	logic                   rsp_valid_q;
	logic [1:0]             status_q;
	logic [HFIELD_BITS-1:0] fired_q;
	logic [PEND_BITS-1:0]   pending_q;

	logic [TIME_BITS-1:0]   cell_time   [DEPTH];
	logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
	logic                   cell_keep   [DEPTH];

	stq_apb u_apb (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.early_slack (early_slack)
	);

	assign wake_sum    = {1'b0, req.now} + (TIME_BITS + 1)'(req.delay);
	assign handle_wide = 32'(req.handle);
	assign req.ready   = !s1_valid_q || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1   <= req.kind;
			wake_s1   <= wake_sum[TIME_BITS] ? '1 : wake_sum[TIME_BITS-1:0];
			thresh_s1 <= {1'b0, req.now} + (TIME_BITS + 1)'(early_slack);
			handle_s1 <= handle_wide[HANDLE_BITS-1:0];
		end
	end

	assign fire = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign full = (count_q == CW'(DEPTH));
	assign due  = (count_q != '0) && ({1'b0, cell_time[0]} < thresh_s1);
	assign head_wide = 32'(cell_handle[0]);

	always_comb begin
		cmd.ins  = 1'b0;
		cmd.pop  = 1'b0;
		cmd.wake = wake_s1;
		count_d  = count_q;
		status_d = ST_NOT_DUE;
		fired_d  = '0;
		unique case (kind_t'(kind_s1))
			KIND_SCHEDULE: begin
				if (full) begin
					status_d = ST_REJECTED;
				end else begin
					status_d = ST_SCHEDULED;
					cmd.ins  = fire;
					count_d  = count_q + CW'(1);
				end
			end
			KIND_POLL: begin
				if (due) begin
					status_d = ST_FIRED;
					fired_d  = head_wide[HFIELD_BITS-1:0];
					cmd.pop  = fire;
					count_d  = count_q - CW'(1);
				end
			end
			default: begin
				status_d = ST_NOT_DUE;
			end
		endcase
	end

	assign count_wide = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_d;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_d;
			fired_q   <= fired_d;
			pending_q <= count_wide[PEND_BITS-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.fired_handle = fired_q;
	assign rsp.pending      = pending_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   prev_keep;
		logic [TIME_BITS-1:0]   prev_time;
		logic [HANDLE_BITS-1:0] prev_handle;
		logic [TIME_BITS-1:0]   next_time;
		logic [HANDLE_BITS-1:0] next_handle;

		if (i == 0) begin : g_first
			assign prev_keep   = 1'b1;
			assign prev_time   = '0;
			assign prev_handle = '0;
		end else begin : g_mid
			assign prev_keep   = cell_keep[i-1];
			assign prev_time   = cell_time[i-1];
			assign prev_handle = cell_handle[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_time   = cell_time[i];
			assign next_handle = cell_handle[i];
		end else begin : g_inner
			assign next_time   = cell_time[i+1];
			assign next_handle = cell_handle[i+1];
		end

		stq_cell #(
			.HANDLE_BITS (HANDLE_BITS)
		) u_cell (
			.clk          (clk),
			.cmd          (cmd),
			.new_handle   (handle_s1),
			.occupied     (CW'(i) < count_q),
			.prev_keep    (prev_keep),
			.prev_time    (prev_time),
			.prev_handle  (prev_handle),
			.next_time    (next_time),
			.next_handle  (next_handle),
			.ent_time_q   (cell_time[i]),
			.ent_handle_q (cell_handle[i]),
			.keep         (cell_keep[i])
		);
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench of the sorted timer event queue: directed table, then random requests.
// A behavioral queue predicts untyped responses; the early slack goes through several values.
// Depends on stq_pkg, stq_if.sv and sorted_timer_event_queue.
module tb_top;
	import stq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam int HB = HANDLE_BITS_DEF;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;
	localparam int SEG_ITEMS = 84;
	localparam int NROWS = 20;

	typedef struct packed {
		status_t                st;
		logic [HFIELD_BITS-1:0] fh;
		logic [PEND_BITS-1:0]   pend;
	} outcome_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] wake;
		logic [HB-1:0]        hnd;
	} timer_rec_t;

	typedef struct packed {
		kind_t                  kind;
		logic [TIME_BITS-1:0]   now;
		logic [DELAY_BITS-1:0]  delay;
		logic [HFIELD_BITS-1:0] handle;
		int                     reps;
		bit                     typed;
		outcome_t               want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic pready;

	stq_req_if req_ch ();
	stq_rsp_if rsp_ch ();

	sorted_timer_event_queue dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch)
	);

	timer_rec_t model_events[$];
	logic [SLACK_BITS-1:0] model_slack;
	outcome_t outcome_q[$];
	bit typed_valid;
	outcome_t typed_outcome;
	int tx_idle_pct, rx_idle_pct;
	int errors, n_requests, n_settings;
	int n_sched, n_reject, n_fired, n_not_due;
	logic [TIME_BITS-1:0] clock_us;

	plan_row_t opening_plan [NROWS] = '{
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 1, 1'b1, '{ST_NOT_DUE, 16'h0, 5'd0}},
		'{KIND_SCHEDULE, 48'd0, 40'd0, 16'hFFFF, 1, 1'b1, '{ST_SCHEDULED, 16'h0, 5'd1}},
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 1, 1'b1, '{ST_FIRED, 16'hFFFF, 5'd0}},
		'{KIND_SCHEDULE, TIME_MAX, DELAY_MAX, 16'h0000, 1, 1'b1,
			'{ST_SCHEDULED, 16'h0, 5'd1}},
		'{KIND_POLL, TIME_MAX, 40'd0, 16'h0000, 1, 1'b1, '{ST_FIRED, 16'h0, 5'd0}},
		'{KIND_SCHEDULE, 48'd0, 40'd10000, 16'h0002, 1, 1'b1,
			'{ST_SCHEDULED, 16'h0, 5'd1}},
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 1, 1'b1, '{ST_NOT_DUE, 16'h0, 5'd1}},
		'{KIND_POLL, 48'd1, 40'd0, 16'h0000, 1, 1'b1, '{ST_FIRED, 16'h0002, 5'd0}},
		'{KIND_SCHEDULE, 48'd500, 40'd500, 16'h000A, 1, 1'b1,
			'{ST_SCHEDULED, 16'h0, 5'd1}},
		'{KIND_SCHEDULE, 48'd0, 40'd1000, 16'h000B, 1, 1'b1,
			'{ST_SCHEDULED, 16'h0, 5'd2}},
		'{KIND_SCHEDULE, 48'd1000, 40'd0, 16'h000C, 1, 1'b1,
			'{ST_SCHEDULED, 16'h0, 5'd3}},
		'{KIND_SCHEDULE, 48'd0, 40'd200, 16'h000D, 1, 1'b0, '{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_SCHEDULE, TIME_MAX - 48'd5, 40'd3, 16'h000E, 1, 1'b0,
			'{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 5, 1'b0, '{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_POLL, TIME_MAX, 40'd0, 16'h0000, 1, 1'b0, '{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_SCHEDULE, 48'd100, 40'd50, 16'h0100, 16, 1'b0,
			'{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_SCHEDULE, 48'd0, 40'd0, 16'h5555, 1, 1'b1, '{ST_REJECTED, 16'h0, 5'd16}},
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 1, 1'b0, '{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_POLL, 48'd200, 40'd0, 16'h0000, 15, 1'b0, '{ST_SCHEDULED, 16'h0, 5'd0}},
		'{KIND_POLL, 48'd0, 40'd0, 16'h0000, 1, 1'b1, '{ST_NOT_DUE, 16'h0, 5'd0}}
	};

	function automatic outcome_t timer_queue_step(kind_t k, logic [TIME_BITS-1:0] now,
			logic [DELAY_BITS-1:0] delay, logic [HFIELD_BITS-1:0] h);
		outcome_t o;
		logic [TIME_BITS:0] wsum;
		logic [TIME_BITS-1:0] wake;
		logic [63:0] limit;
		int pos;
		timer_rec_t rec;
		o.fh = '0;
		if (k == KIND_SCHEDULE) begin
			wsum = {1'b0, now} + {{(TIME_BITS - DELAY_BITS + 1){1'b0}}, delay};
			wake = wsum[TIME_BITS] ? TIME_MAX : wsum[TIME_BITS-1:0];
			if (model_events.size() >= QDEPTH) begin
				o.st = ST_REJECTED;
			end else begin
				pos = 0;
				while (pos < model_events.size() && model_events[pos].wake <= wake)
					pos++;
				rec.wake = wake;
				rec.hnd = h[HB-1:0];
				model_events.insert(pos, rec);
				o.st = ST_SCHEDULED;
			end
		end else begin
			limit = 64'(now) + 64'(model_slack);
			if (model_events.size() > 0 && 64'(model_events[0].wake) < limit) begin
				o.st = ST_FIRED;
				o.fh = HFIELD_BITS'(model_events[0].hnd);
				void'(model_events.pop_front());
			end else begin
				o.st = ST_NOT_DUE;
			end
		end
		o.pend = PEND_BITS'(model_events.size());
		return o;
	endfunction

	function automatic void flag_error(string what);
		errors++;
		if (errors <= 10)
			$display("[%0t] ERROR: %s", $realtime, what);
	endfunction

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready = (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		outcome_t model;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			model = timer_queue_step(kind_t'(req_ch.kind), req_ch.now, req_ch.delay,
				req_ch.handle);
			outcome_q.push_back(typed_valid ? typed_outcome : model);
			n_requests++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.st = status_t'(rsp_ch.status);
			got.fh = rsp_ch.fired_handle;
			got.pend = rsp_ch.pending;
			if (outcome_q.size() == 0) begin
				flag_error($sformatf("response with no request waiting: status %0d", got.st));
			end else begin
				want = outcome_q.pop_front();
				if (got.st !== want.st || got.fh !== want.fh || got.pend !== want.pend)
					flag_error($sformatf(
						"expected status %0d handle %h pending %0d, got %0d %h %0d",
						want.st, want.fh, want.pend, got.st, got.fh, got.pend));
			end
			case (got.st)
				ST_SCHEDULED: n_sched++;
				ST_REJECTED:  n_reject++;
				ST_FIRED:     n_fired++;
				default:      n_not_due++;
			endcase
		end
	end

	task automatic send_request(kind_t k, logic [TIME_BITS-1:0] now,
			logic [DELAY_BITS-1:0] delay, logic [HFIELD_BITS-1:0] h,
			bit typed, outcome_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind = k;
		req_ch.now = now;
		req_ch.delay = delay;
		req_ch.handle = h;
		typed_valid = typed;
		typed_outcome = want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_outcomes();
		req_ch.valid = 1'b0;
		typed_valid = 1'b0;
		while (outcome_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(reg_index_t idx, logic [DATA_BITS-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_EARLY_SLACK)
			model_slack = data[SLACK_BITS-1:0];
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apb_check_slack();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {REG_EARLY_SLACK, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== DATA_BITS'(model_slack))
			flag_error($sformatf("early slack reads %h, expected %h", prdata, model_slack));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	initial begin
		logic [SLACK_BITS-1:0] seg_slack;
		logic [DATA_BITS-1:0] wdata;
		logic [TIME_BITS-1:0] now;
		logic [DELAY_BITS-1:0] delay;
		kind_t k;
		bit filling;
		int r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_SCHEDULE;
		req_ch.now = '0;
		req_ch.delay = '0;
		req_ch.handle = '0;
		rsp_ch.ready = 1'b0;
		typed_valid = 1'b0;
		typed_outcome = '0;
		model_slack = SLACK_RESET;
		tx_idle_pct = 18;
		rx_idle_pct = 79;
		errors = 0;
		n_requests = 0;
		n_settings = 1;
		n_sched = 0;
		n_reject = 0;
		n_fired = 0;
		n_not_due = 0;
		clock_us = '0;
		filling = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < NROWS; i++)
			for (int j = 0; j < opening_plan[i].reps; j++)
				send_request(opening_plan[i].kind, opening_plan[i].now,
					opening_plan[i].delay,
					opening_plan[i].handle + HFIELD_BITS'(j),
					opening_plan[i].typed, opening_plan[i].want);
		drain_outcomes();
		apb_check_slack();

		for (int seg = 0; seg < 6; seg++) begin
			drain_outcomes();
			case (seg)
				0: wdata = 32'd0;
				1: wdata = 32'h000F_FFFF;
				2: wdata = 32'd1000000;
				4: wdata = 32'd10000;
				default: wdata = $urandom;
			endcase
			if (seg == 2)
				apb_write(REG_UNUSED, $urandom);
			apb_write(REG_EARLY_SLACK, wdata);
			apb_check_slack();
			n_settings++;
			seg_slack = model_slack;
			tx_idle_pct = (seg < 2) ? 18 : (seg < 4) ? 79 : 0;
			rx_idle_pct = (seg < 2) ? 79 : (seg < 4) ? 18 : 0;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (n % 24 == 23)
					filling = !filling;
				k = ($urandom_range(99) < (filling ? 75 : 25)) ? KIND_SCHEDULE : KIND_POLL;
				r = $urandom_range(99);
				if (r < 5) begin
					now = TIME_BITS'({$urandom, $urandom});
				end else if (r < 8) begin
					now = TIME_MAX - TIME_BITS'($urandom_range(3));
				end else begin
					clock_us = clock_us + TIME_BITS'($urandom_range(4000));
					now = clock_us;
				end
				r = $urandom_range(99);
				if (r < 5)
					delay = DELAY_BITS'({$urandom, $urandom});
				else if (r < 8)
					delay = DELAY_MAX;
				else
					delay = DELAY_BITS'($urandom_range(20000));
				send_request(k, now, delay, HFIELD_BITS'($urandom), 1'b0, '0);
			end
			if (seg == 3) begin
				// Hold the request side until the queue has answered everything.
				drain_outcomes();
				send_request(KIND_POLL, TIME_MAX, DELAY_MAX, '1, 1'b0, '0);
			end
			if (seg_slack != model_slack)
				flag_error("early slack changed during traffic");
		end

		drain_outcomes();
		repeat (10) @(negedge clk);
		$display("Run covered %0d requests over %0d early-slack settings.",
			n_requests, n_settings);
		$display("Responses: %0d scheduled, %0d rejected, %0d fired, %0d not due, %0d errors.",
			n_sched, n_reject, n_fired, n_not_due, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
